// ----- hdl/deq_pkg.sv -----
// Package: depth, widths, operation and status codes of the double-ended queue.
`default_nettype none
package deq_pkg;
    localparam int DEPTH = 1024;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OP_W = 3;
    localparam int WORD_W = 32;
    localparam int STAT_W = 2;
    localparam int SIZE_W = 11;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK       = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        return (i == IDX_LAST) ? '0 : IDX_W'(i + 1'b1);
    endfunction

    function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_LAST : IDX_W'(i - 1'b1);
    endfunction
endpackage
`default_nettype wire

// ----- hdl/deq_if.sv -----
// Interfaces: request and response channels of the double-ended queue.
`default_nettype none
interface deq_req_if import deq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [WORD_W-1:0] push_value;

    modport source (output valid, output operation, output push_value, input ready);
    modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] popped_value;
    logic [SIZE_W-1:0]        size_now;
    logic                     is_empty;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;

    modport source (output valid, output status, output popped_value, output size_now,
                    output is_empty, output front_value, output back_value, input ready);
    modport sink   (input valid, input status, input popped_value, input size_now,
                    input is_empty, input front_value, input back_value, output ready);
endinterface
`default_nettype wire

// ----- hdl/double_ended_queue.sv -----
// Top level: double-ended queue on a circular entry store with head, tail and count.
// Push, peek and any failed or emptying pop: response registered in the cycle after the request.
// A pop that leaves entries behind: one store read; the response is registered in the S_READ state.
// Throughput: one request per cycle while the response is taken; none while a pop's store read is pending.
// Reset clears head, tail, count and the response valid; store contents are not cleared.
`default_nettype none
module double_ended_queue import deq_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    deq_req_if.sink  i_req,
    deq_rsp_if.source o_rsp
);
    typedef enum logic {S_IDLE, S_READ} t_state;

    t_state            r_state;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [WORD_W-1:0] r_front, n_front;
    logic [WORD_W-1:0] r_back, n_back;
    logic              r_pend_front;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic [WORD_W-1:0] r_popped, n_popped;
    logic [SIZE_W-1:0] r_size;
    logic              r_empty;
    logic [WORD_W-1:0] r_out_front;
    logic [WORD_W-1:0] r_out_back;

    logic              accept;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en, n_pend_front;
    logic [IDX_W-1:0]  rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic [SIZE_W+CNT_W-1:0] size_ext;

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept = i_req.valid && i_req.ready;
    assign size_ext = {{SIZE_W{1'b0}}, n_cnt};

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_cnt = r_cnt;
        n_front = r_front;
        n_back = r_back;
        n_status = STAT_OK;
        n_popped = '0;
        wr_en = 1'b0;
        wr_addr = r_tail;
        rd_en = 1'b0;
        rd_addr = r_head;
        n_pend_front = 1'b0;
        case (i_req.operation)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (r_cnt == CNT_FULL) begin
                    n_status = STAT_FULL;
                end else begin
                    wr_en = accept;
                    n_cnt = CNT_W'(r_cnt + 1'b1);
                    if (i_req.operation == OP_PUSH_FRONT) begin
                        n_head = prev_idx(r_head);
                        wr_addr = n_head;
                        n_front = i_req.push_value;
                        if (r_cnt == '0) begin
                            n_back = i_req.push_value;
                        end
                    end else begin
                        wr_addr = r_tail;
                        n_tail = next_idx(r_tail);
                        n_back = i_req.push_value;
                        if (r_cnt == '0) begin
                            n_front = i_req.push_value;
                        end
                    end
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (r_cnt == '0) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_cnt = CNT_W'(r_cnt - 1'b1);
                    rd_en = accept && (r_cnt > CNT_W'(1));
                    if (i_req.operation == OP_POP_FRONT) begin
                        n_popped = r_front;
                        n_head = next_idx(r_head);
                        rd_addr = n_head;
                        n_pend_front = 1'b1;
                    end else begin
                        n_popped = r_back;
                        n_tail = prev_idx(r_tail);
                        rd_addr = prev_idx(n_tail);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    deq_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_req.push_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            r_head <= '0;
            r_tail <= '0;
            r_cnt <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_head <= n_head;
                        r_tail <= n_tail;
                        r_cnt <= n_cnt;
                        r_front <= n_front;
                        r_back <= n_back;
                        r_status <= n_status;
                        r_popped <= n_popped;
                        r_size <= size_ext[SIZE_W-1:0];
                        r_empty <= (n_cnt == '0);
                        r_out_front <= (n_cnt == '0) ? '0 : n_front;
                        r_out_back <= (n_cnt == '0) ? '0 : n_back;
                        r_pend_front <= n_pend_front;
                        if (rd_en) begin
                            r_state <= S_READ;
                            r_out_valid <= 1'b0;
                        end else begin
                            r_out_valid <= 1'b1;
                        end
                    end else if (r_out_valid && o_rsp.ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_READ: begin
                    if (r_pend_front) begin
                        r_front <= rd_data;
                        r_out_front <= rd_data;
                    end else begin
                        r_back <= rd_data;
                        r_out_back <= rd_data;
                    end
                    r_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.status = r_status;
    assign o_rsp.popped_value = r_popped;
    assign o_rsp.size_now = r_size;
    assign o_rsp.is_empty = r_empty;
    assign o_rsp.front_value = r_out_front;
    assign o_rsp.back_value = r_out_back;
endmodule
`default_nettype wire

// ----- hdl/deq_store.sv -----
// Entry store: one write port and one read port with registered read data.
`default_nettype none
module deq_store import deq_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [IDX_W-1:0]  i_wr_addr,
    input  wire logic [WORD_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [IDX_W-1:0]  i_rd_addr,
    output logic      [WORD_W-1:0] o_rd_data
);
    logic [WORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire
